// ===== rtl/asw_pkg.sv =====
// shared types and constants for the antipodal sphere wrap block
`default_nettype none
package asw_pkg;

    localparam int GRID_EDGE_DEF = 64;
    localparam int IN_W          = 8;
    localparam int OUT_W         = 6;
    localparam int FRAC_W        = 16;

    typedef logic signed [IN_W-1:0] t_coord;
    typedef logic [OUT_W-1:0]       t_wrap;

endpackage
`default_nettype wire

// ===== rtl/asw_if.sv =====
// stream interfaces for coordinate requests and wrapped results
`default_nettype none
interface asw_coord_if;
    logic            valid;
    logic            ready;
    asw_pkg::t_coord coord_x;
    asw_pkg::t_coord coord_y;
    asw_pkg::t_coord coord_z;

    modport source (output valid, coord_x, coord_y, coord_z, input ready);
    modport sink   (input valid, coord_x, coord_y, coord_z, output ready);
endinterface

interface asw_wrap_if;
    logic           valid;
    logic           ready;
    asw_pkg::t_wrap wrapped_x;
    asw_pkg::t_wrap wrapped_y;
    asw_pkg::t_wrap wrapped_z;
    logic           took_antipode;

    modport source (output valid, wrapped_x, wrapped_y, wrapped_z, took_antipode,
                    input ready);
    modport sink   (input valid, wrapped_x, wrapped_y, wrapped_z, took_antipode,
                    output ready);
endinterface
`default_nettype wire

// ===== rtl/antipodal_sphere_wrap.sv =====
// antipodal sphere wrap: pipelined coordinate wrap into the inscribed sphere
//
// i_coord carries one signed coordinate triple per request (valid/ready),
// o_wrap returns one wrapped triple plus the took_antipode flag per request.
// A request can enter every cycle unless o_wrap stalls; throughput is then one per cycle.
// QW is the root width (one pipeline stage per root bit) and NW the
// quotient width (one stage per quotient bit).
// With GRID_EDGE = 64: QW = 26 and NW = 6.
// The root pipeline (one restoring square-root step per stage) sets the
// depth; the three axis dividers run in parallel behind it.
// Reset (synchronous, active low) empties the pipeline; no results are lost
// or duplicated on stalls: when o_wrap is held off with a result waiting,
// the whole pipeline freezes and i_coord.ready drops until o_wrap takes it.
// Results leave in request order.
`default_nettype none
module antipodal_sphere_wrap #(
    parameter int GRID_EDGE = asw_pkg::GRID_EDGE_DEF
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    asw_coord_if.sink       i_coord,
    asw_wrap_if.source      o_wrap
);
    import asw_pkg::*;

    localparam int D_MAX  = (1 << IN_W) + GRID_EDGE - 1;
    localparam int MW     = $clog2(D_MAX + 1);
    localparam int DW     = MW + 1;
    localparam int SQW    = $clog2(D_MAX * D_MAX + 1);
    localparam int SW     = $clog2(3 * D_MAX * D_MAX + 1);
    localparam int RAD_W  = SW + 2 * FRAC_W;
    localparam int QW     = (RAD_W + 1) / 2;
    localparam int XW     = 2 * QW;
    localparam int REM_W  = QW + 3;
    localparam int LIM    = (GRID_EDGE + 1) * (GRID_EDGE + 1);
    localparam int NW     = $clog2(GRID_EDGE / 2 + 1);
    localparam int VW     = QW + 1;
    localparam int NUMW   = NW + VW;

    typedef struct packed {
        logic                       outside;
        logic [2:0]                 neg;
        logic [2:0][MW-1:0]         mag;
        logic [2:0][OUT_W-1:0]      inres;
    } t_side;

    logic en;
    logic r_ov;
    assign en = !r_ov || o_wrap.ready;
    assign i_coord.ready = en;

    // stage 1: doubled coordinates, magnitudes, inside-path clamp
    t_coord w_c [3];
    assign w_c[0] = i_coord.coord_x;
    assign w_c[1] = i_coord.coord_y;
    assign w_c[2] = i_coord.coord_z;

    t_side n_side1;
    always_comb begin
        logic signed [DW-1:0] d;
        int ci;
        n_side1 = '0;
        for (int a = 0; a < 3; a++) begin
            d = (DW'(w_c[a]) <<< 1) - DW'(GRID_EDGE - 1);
            n_side1.neg[a] = d[DW-1];
            n_side1.mag[a] = d[DW-1] ? MW'(-d) : MW'(d);
            ci = int'(w_c[a]);
            if (ci < 0) begin
                ci = 0;
            end else if (ci > GRID_EDGE - 1) begin
                ci = GRID_EDGE - 1;
            end
            n_side1.inres[a] = OUT_W'(ci);
        end
    end

    logic  r_v1;
    t_side r_side1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_coord.valid;
        end
        if (en) begin
            r_side1 <= n_side1;
        end
    end

    // stage 2: squares
    logic                r_v2;
    t_side               r_side2;
    logic [2:0][SQW-1:0] r_sq2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1;
        end
        if (en) begin
            r_side2 <= r_side1;
            for (int a = 0; a < 3; a++) begin
                r_sq2[a] <= SQW'(SQW'(r_side1.mag[a]) * SQW'(r_side1.mag[a]));
            end
        end
    end

    // stage 3: sum of squares and sphere test, feeds the root pipeline
    logic [SW-1:0] n_s;
    assign n_s = SW'(r_sq2[0]) + SW'(r_sq2[1]) + SW'(r_sq2[2]);

    t_side n_side3;
    always_comb begin
        n_side3         = r_side2;
        n_side3.outside = (n_s > SW'(LIM));
    end

    logic              r_sv    [0:QW];
    t_side             r_sside [0:QW];
    logic [SW-1:0]     r_ss    [0:QW];
    logic [REM_W-1:0]  r_srem  [0:QW];
    logic [QW-1:0]     r_sroot [0:QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else if (en) begin
            r_sv[0] <= r_v2;
        end
        if (en) begin
            r_sside[0] <= n_side3;
            r_ss[0]    <= n_s;
            r_srem[0]  <= '0;
            r_sroot[0] <= '0;
        end
    end

    // root pipeline: one result bit per stage, radicand is S * 2^32
    for (genvar k = 0; k < QW; k++) begin : g_sqrt
        localparam int P = QW - 1 - k;
        logic [XW-1:0]    x;
        logic [REM_W-1:0] shifted;
        logic [REM_W-1:0] trial;
        logic             take;
        assign x       = XW'({r_ss[k], {(2 * FRAC_W){1'b0}}});
        assign shifted = {r_srem[k][REM_W-3:0], x[2*P+1 -: 2]};
        assign trial   = REM_W'({r_sroot[k], 2'b01});
        assign take    = (shifted >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[k+1] <= 1'b0;
            end else if (en) begin
                r_sv[k+1] <= r_sv[k];
            end
            if (en) begin
                r_sside[k+1] <= r_sside[k];
                r_ss[k+1]    <= r_ss[k];
                r_srem[k+1]  <= take ? shifted - trial : shifted;
                r_sroot[k+1] <= {r_sroot[k][QW-2:0], take};
            end
        end
    end

    // numerator |D|*E*2^16 + q and divisor 2q, feeds the divider pipeline
    logic                 r_dv   [0:NW];
    t_side                r_dside[0:NW];
    logic [VW-1:0]        r_ddiv [0:NW];
    logic [2:0][NUMW-1:0] r_drem [0:NW];
    logic [2:0][NW-1:0]   r_dq   [0:NW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (en) begin
            r_dv[0] <= r_sv[QW];
        end
        if (en) begin
            r_dside[0] <= r_sside[QW];
            r_ddiv[0]  <= {r_sroot[QW], 1'b0};
            for (int a = 0; a < 3; a++) begin
                r_drem[0][a] <= ((NUMW'(r_sside[QW].mag[a]) * NUMW'(GRID_EDGE)) << FRAC_W)
                                + NUMW'(r_sroot[QW]);
            end
            r_dq[0] <= '0;
        end
    end

    // divider pipeline: one quotient bit per stage on all three axes
    for (genvar k = 0; k < NW; k++) begin : g_div
        localparam int J = NW - 1 - k;
        logic [NUMW-1:0] dsh;
        assign dsh = NUMW'(r_ddiv[k]) << J;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1] <= 1'b0;
            end else if (en) begin
                r_dv[k+1] <= r_dv[k];
            end
            if (en) begin
                r_dside[k+1] <= r_dside[k];
                r_ddiv[k+1]  <= r_ddiv[k];
                for (int a = 0; a < 3; a++) begin
                    if (r_drem[k][a] >= dsh) begin
                        r_drem[k+1][a] <= r_drem[k][a] - dsh;
                        r_dq[k+1][a]   <= r_dq[k][a] | NW'(1 << J);
                    end else begin
                        r_drem[k+1][a] <= r_drem[k][a];
                        r_dq[k+1][a]   <= r_dq[k][a];
                    end
                end
            end
        end
    end

    // output: reflect through center, clamp, pick path
    logic [2:0][OUT_W-1:0] n_res;
    always_comb begin
        int v;
        for (int a = 0; a < 3; a++) begin
            v = int'(r_dq[NW][a]);
            if (r_dside[NW].neg[a]) begin
                v = GRID_EDGE / 2 + v;
            end else begin
                v = GRID_EDGE / 2 - v;
            end
            if (v < 0) begin
                v = 0;
            end else if (v > GRID_EDGE - 1) begin
                v = GRID_EDGE - 1;
            end
            n_res[a] = r_dside[NW].outside ? OUT_W'(v) : r_dside[NW].inres[a];
        end
    end

    logic [2:0][OUT_W-1:0] r_ores;
    logic                  r_oant;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_dv[NW];
        end
        if (en) begin
            r_ores <= n_res;
            r_oant <= r_dside[NW].outside;
        end
    end

    assign o_wrap.valid         = r_ov;
    assign o_wrap.wrapped_x     = r_ores[0];
    assign o_wrap.wrapped_y     = r_ores[1];
    assign o_wrap.wrapped_z     = r_ores[2];
    assign o_wrap.took_antipode = r_oant;

endmodule
`default_nettype wire
